FILE: design/bgu_pkg.sv
// types, constants and helpers shared by the bilinear grid upsampler
// no dependencies; used by every module of the block except bgu_ram
package bgu_pkg;

  localparam int VAL_W      = 32;
  localparam int CRD_W      = 6;
  localparam int FINE_W     = 12;
  localparam int RATIO_W    = 7;
  localparam int CX_W       = FINE_W + 1;
  localparam int DEN_W      = 2 * RATIO_W;
  localparam int W_W        = DEN_W;
  localparam int PROD_W     = VAL_W + W_W + 1;
  localparam int ACC_W      = VAL_W + DEN_W + 2;
  localparam int DVD_W      = VAL_W + DEN_W;
  localparam int CNT_W      = $clog2(VAL_W + 1);
  localparam int NVAL       = 3;
  localparam int NWGT       = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RATIO_W;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 96;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_Y = 3'd4;

  localparam logic [RATIO_W-1:0] RATIO_RST = 7'd1;
  localparam logic [CRD_W-1:0]   ORG_RST   = 6'd0;
  localparam logic [CRD_W-1:0]   LAST_RST  = 6'd63;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_DXW,
    ST_DY,
    ST_DYW,
    ST_WGT,
    ST_MAC,
    ST_RND,
    ST_DVS,
    ST_DVW,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DEN_W-1:0]   hi;
    logic [VAL_W-1:0]   lo;
    logic [DEN_W-1:0]   dvs;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VAL_W-1:0]   quo;
    logic [DEN_W-1:0]   rem;
  } div_rsp_t;

  typedef struct packed {
    logic clr;
    logic add;
  } mac_ctl_t;

  function automatic logic [CRD_W-1:0] clamp_idx(input logic [CX_W-1:0] c,
                                                 input logic [CRD_W-1:0] lim);
    logic [CRD_W-1:0] res;
    if (c > {{(CX_W-CRD_W){1'b0}}, lim}) res = lim;
    else res = c[CRD_W-1:0];
    return res;
  endfunction

endpackage

FILE: design/bilinear_grid_upsampler.sv
// top level: config registers, sequencer, coarse node stores and output register
// depends on bgu_pkg, bgu_ram, bgu_divider, bgu_mac
//
// channel  dir  handshake             payload
// in       in   in_tvalid/in_tready   tuser: opcode; tdata: coarse_x, coarse_y, fine_x,
//                                     fine_y, rho_in, ux_in, uy_in
// out      out  out_tvalid/out_tready tdata: rho_out, ux_out, uy_out
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a query keeps in_tready low while the serial divider splits each fine coordinate, the
// shared multiplier forms the weights, then for each value the multiplier sums and the
// divider divides, and finally the output register is loaded
// in_tready is high only while the sequencer is idle; cfg_ready is always high
// the result waits in the output register, so the next beat is taken while it stalls
// reset is synchronous; the coarse stores are not cleared
module bilinear_grid_upsampler #(
  parameter int COARSE_SIDE = 64,
  parameter int MAX_RATIO   = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // opcode
  input  logic                                in_tuser,
  // coarse_x, coarse_y, fine_x, fine_y, rho_in, ux_in, uy_in, zero pad
  input  logic [bgu_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // rho_out, ux_out, uy_out
  output logic [bgu_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bgu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bgu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = COARSE_SIDE * COARSE_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [2:0] STEP_LAST = 3'd5;
  localparam logic [bgu_pkg::CRD_W-1:0] SIDE_LAST = bgu_pkg::CRD_W'(COARSE_SIDE - 1);

  // input fields
  logic [bgu_pkg::CRD_W-1:0]   in_cx;
  logic [bgu_pkg::CRD_W-1:0]   in_cy;
  logic [bgu_pkg::FINE_W-1:0]  in_fx;
  logic [bgu_pkg::FINE_W-1:0]  in_fy;
  logic [bgu_pkg::VAL_W-1:0]   in_val [bgu_pkg::NVAL];

  assign in_cx     = in_tdata[5:0];
  assign in_cy     = in_tdata[11:6];
  assign in_fx     = in_tdata[23:12];
  assign in_fy     = in_tdata[35:24];
  assign in_val[0] = in_tdata[67:36];
  assign in_val[1] = in_tdata[99:68];
  assign in_val[2] = in_tdata[131:100];

  // config registers
  logic [bgu_pkg::RATIO_W-1:0] ratio_r;
  logic [bgu_pkg::CRD_W-1:0]   org_x_r;
  logic [bgu_pkg::CRD_W-1:0]   org_y_r;
  logic [bgu_pkg::CRD_W-1:0]   last_x_r;
  logic [bgu_pkg::CRD_W-1:0]   last_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= bgu_pkg::RATIO_RST;
      org_x_r  <= bgu_pkg::ORG_RST;
      org_y_r  <= bgu_pkg::ORG_RST;
      last_x_r <= bgu_pkg::LAST_RST;
      last_y_r <= bgu_pkg::LAST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bgu_pkg::CFG_RATIO:  ratio_r  <= cfg_data;
        bgu_pkg::CFG_ORG_X:  org_x_r  <= cfg_data[bgu_pkg::CRD_W-1:0];
        bgu_pkg::CFG_ORG_Y:  org_y_r  <= cfg_data[bgu_pkg::CRD_W-1:0];
        bgu_pkg::CFG_LAST_X: last_x_r <= cfg_data[bgu_pkg::CRD_W-1:0];
        bgu_pkg::CFG_LAST_Y: last_y_r <= cfg_data[bgu_pkg::CRD_W-1:0];
        default: ;
      endcase
    end
  end

  // effective ratio and clamp limits
  logic [bgu_pkg::RATIO_W-1:0] r_eff;
  logic [bgu_pkg::CRD_W-1:0]   lim_x;
  logic [bgu_pkg::CRD_W-1:0]   lim_y;

  always_comb begin
    priority if (ratio_r == '0) begin
      r_eff = bgu_pkg::RATIO_W'(1);
    end else if (32'(ratio_r) > MAX_RATIO) begin
      r_eff = bgu_pkg::RATIO_W'(MAX_RATIO);
    end else begin
      r_eff = ratio_r;
    end
    lim_x = (32'(last_x_r) > COARSE_SIDE - 1) ? SIDE_LAST : last_x_r;
    lim_y = (32'(last_y_r) > COARSE_SIDE - 1) ? SIDE_LAST : last_y_r;
  end

  // sequencer state
  bgu_pkg::state_t state_r, state_nxt;
  logic [2:0]                    step_r;
  logic [1:0]                    v_r;
  logic [bgu_pkg::FINE_W-1:0]    fx_r;
  logic [bgu_pkg::FINE_W-1:0]    fy_r;
  logic [bgu_pkg::RATIO_W-1:0]   a_r;
  logic [bgu_pkg::RATIO_W-1:0]   b_r;
  logic [bgu_pkg::CRD_W-1:0]     x0_r, x1_r, y0_r, y1_r;
  logic [bgu_pkg::W_W-1:0]       wgt_r [bgu_pkg::NWGT];
  logic signed [bgu_pkg::ACC_W-1:0] num_r;
  logic [bgu_pkg::VAL_W-1:0]     res_r [bgu_pkg::NVAL];
  logic                          out_valid_r;
  logic [bgu_pkg::OUT_TDATA_W-1:0] out_data_r;

  bgu_pkg::div_req_t div_req;
  bgu_pkg::div_rsp_t div_rsp;
  bgu_pkg::mac_ctl_t mac_ctl;
  logic signed [bgu_pkg::VAL_W-1:0]  mac_a;
  logic        [bgu_pkg::W_W-1:0]    mac_b;
  logic signed [bgu_pkg::PROD_W-1:0] mac_prod;
  logic signed [bgu_pkg::ACC_W-1:0]  mac_acc;

  logic                          in_acc;
  logic                          out_load;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [bgu_pkg::VAL_W-1:0]     ram_q [bgu_pkg::NVAL];
  logic [bgu_pkg::RATIO_W-1:0]   ra, rb;
  logic [2:0]                    widx;
  logic [bgu_pkg::CRD_W-1:0]     rd_x, rd_y;
  logic [bgu_pkg::ACC_W-1:0]     mag;
  logic [bgu_pkg::CX_W-1:0]      c0x, c0y;

  assign in_tready = (state_r == bgu_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == bgu_pkg::ST_FIN) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bgu_pkg::ST_IDLE: if (in_acc && in_tuser == bgu_pkg::OP_QUERY) begin
        state_nxt = bgu_pkg::ST_DX;
      end
      bgu_pkg::ST_DX:   state_nxt = bgu_pkg::ST_DXW;
      bgu_pkg::ST_DXW:  if (div_rsp.done) state_nxt = bgu_pkg::ST_DY;
      bgu_pkg::ST_DY:   state_nxt = bgu_pkg::ST_DYW;
      bgu_pkg::ST_DYW:  if (div_rsp.done) state_nxt = bgu_pkg::ST_WGT;
      bgu_pkg::ST_WGT:  if (step_r == STEP_LAST) state_nxt = bgu_pkg::ST_MAC;
      bgu_pkg::ST_MAC:  if (step_r == STEP_LAST) state_nxt = bgu_pkg::ST_RND;
      bgu_pkg::ST_RND:  state_nxt = bgu_pkg::ST_DVS;
      bgu_pkg::ST_DVS:  state_nxt = bgu_pkg::ST_DVW;
      bgu_pkg::ST_DVW:  if (div_rsp.done) begin
        state_nxt = (v_r == 2'(bgu_pkg::NVAL - 1)) ? bgu_pkg::ST_FIN : bgu_pkg::ST_MAC;
      end
      bgu_pkg::ST_FIN:  if (out_load) state_nxt = bgu_pkg::ST_IDLE;
      default:          state_nxt = bgu_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ra    = r_eff - a_r;
    rb    = r_eff - b_r;
    widx  = (step_r == '0) ? '0 : step_r - 3'd1;
    rd_x  = step_r[0] ? x1_r : x0_r;
    rd_y  = step_r[1] ? y1_r : y0_r;
    mag   = num_r[bgu_pkg::ACC_W-1] ?
            (~num_r + {{(bgu_pkg::ACC_W-bgu_pkg::W_W){1'b0}}, wgt_r[bgu_pkg::NWGT-1]}) :
            num_r;

    div_req.start = 1'b0;
    div_req.hi    = '0;
    div_req.lo    = '0;
    div_req.dvs   = bgu_pkg::DEN_W'(r_eff);
    div_req.nbits = bgu_pkg::CNT_W'(bgu_pkg::FINE_W);
    mac_ctl.clr   = 1'b0;
    mac_ctl.add   = 1'b0;
    mac_a         = '0;
    mac_b         = '0;

    unique case (state_r)
      bgu_pkg::ST_DX: begin
        div_req.start = 1'b1;
        div_req.lo    = {fx_r, {(bgu_pkg::VAL_W-bgu_pkg::FINE_W){1'b0}}};
      end
      bgu_pkg::ST_DY: begin
        div_req.start = 1'b1;
        div_req.lo    = {fy_r, {(bgu_pkg::VAL_W-bgu_pkg::FINE_W){1'b0}}};
      end
      bgu_pkg::ST_WGT: begin
        unique case (step_r)
          3'd0: begin
            mac_a = {{(bgu_pkg::VAL_W-bgu_pkg::RATIO_W){1'b0}}, ra};
            mac_b = bgu_pkg::W_W'(rb);
          end
          3'd1: begin
            mac_a = {{(bgu_pkg::VAL_W-bgu_pkg::RATIO_W){1'b0}}, a_r};
            mac_b = bgu_pkg::W_W'(rb);
          end
          3'd2: begin
            mac_a = {{(bgu_pkg::VAL_W-bgu_pkg::RATIO_W){1'b0}}, ra};
            mac_b = bgu_pkg::W_W'(b_r);
          end
          3'd3: begin
            mac_a = {{(bgu_pkg::VAL_W-bgu_pkg::RATIO_W){1'b0}}, a_r};
            mac_b = bgu_pkg::W_W'(b_r);
          end
          default: begin
            mac_a = {{(bgu_pkg::VAL_W-bgu_pkg::RATIO_W){1'b0}}, r_eff};
            mac_b = bgu_pkg::W_W'(r_eff);
          end
        endcase
      end
      bgu_pkg::ST_MAC: begin
        mac_a       = ram_q[v_r];
        mac_b       = wgt_r[widx];
        mac_ctl.clr = (step_r == '0);
        mac_ctl.add = (step_r >= 3'd2);
      end
      bgu_pkg::ST_DVS: begin
        div_req.start = 1'b1;
        div_req.hi    = mag[bgu_pkg::DVD_W-1:bgu_pkg::VAL_W];
        div_req.lo    = mag[bgu_pkg::VAL_W-1:0];
        div_req.dvs   = wgt_r[bgu_pkg::NWGT-1];
        div_req.nbits = bgu_pkg::CNT_W'(bgu_pkg::VAL_W);
      end
      default: ;
    endcase
  end

  // coarse node stores
  assign ram_we    = in_acc && (in_tuser == bgu_pkg::OP_WRITE) &&
                     (32'(in_cx) < COARSE_SIDE) && (32'(in_cy) < COARSE_SIDE);
  assign ram_waddr = AW'(32'(in_cy) * COARSE_SIDE + 32'(in_cx));
  assign ram_raddr = AW'(32'(rd_y) * COARSE_SIDE + 32'(rd_x));

  for (genvar g = 0; g < bgu_pkg::NVAL; g++) begin : g_store
    bgu_ram #(
      .WIDTH (bgu_pkg::VAL_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (in_val[g]),
      .raddr (ram_raddr),
      .rdata (ram_q[g])
    );
  end

  bgu_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bgu_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bgu_pkg::ST_IDLE;
      step_r      <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == bgu_pkg::ST_WGT || state_r == bgu_pkg::ST_MAC) && step_r != STEP_LAST) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (in_acc) begin
        v_r <= '0;
      end else if (state_r == bgu_pkg::ST_DVW && div_rsp.done) begin
        v_r <= v_r + 2'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  assign c0x = bgu_pkg::CX_W'(org_x_r) + bgu_pkg::CX_W'(div_rsp.quo[bgu_pkg::FINE_W-1:0]);
  assign c0y = bgu_pkg::CX_W'(org_y_r) + bgu_pkg::CX_W'(div_rsp.quo[bgu_pkg::FINE_W-1:0]);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fx_r <= in_fx;
      fy_r <= in_fy;
    end
    if (state_r == bgu_pkg::ST_DXW && div_rsp.done) begin
      a_r  <= div_rsp.rem[bgu_pkg::RATIO_W-1:0];
      x0_r <= bgu_pkg::clamp_idx(c0x, lim_x);
      x1_r <= bgu_pkg::clamp_idx(c0x + bgu_pkg::CX_W'(1), lim_x);
    end
    if (state_r == bgu_pkg::ST_DYW && div_rsp.done) begin
      b_r  <= div_rsp.rem[bgu_pkg::RATIO_W-1:0];
      y0_r <= bgu_pkg::clamp_idx(c0y, lim_y);
      y1_r <= bgu_pkg::clamp_idx(c0y + bgu_pkg::CX_W'(1), lim_y);
    end
    if (state_r == bgu_pkg::ST_WGT && step_r != '0) begin
      wgt_r[widx] <= mac_prod[bgu_pkg::W_W-1:0];
    end
    if (state_r == bgu_pkg::ST_RND) begin
      num_r <= mac_acc + {{(bgu_pkg::ACC_W-bgu_pkg::W_W){1'b0}}, wgt_r[bgu_pkg::NWGT-1] >> 1};
    end
    if (state_r == bgu_pkg::ST_DVW && div_rsp.done) begin
      res_r[v_r] <= num_r[bgu_pkg::ACC_W-1] ? (~div_rsp.quo + bgu_pkg::VAL_W'(1)) : div_rsp.quo;
    end
    if (out_load) begin
      out_data_r <= {res_r[2], res_r[1], res_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/bgu_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module bgu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bgu_divider.sv
// restoring divider, one quotient bit per cycle, shared by coordinate and value division
// depends on bgu_pkg
module bgu_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  bgu_pkg::div_req_t  req,
  output bgu_pkg::div_rsp_t  rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [bgu_pkg::CNT_W-1:0]   cnt_r;
  logic [bgu_pkg::DEN_W-1:0]   dvs_r;
  logic [bgu_pkg::VAL_W-1:0]   lo_r;
  logic [bgu_pkg::DEN_W-1:0]   rem_r;
  logic [bgu_pkg::VAL_W-1:0]   quo_r;
  logic [bgu_pkg::DEN_W:0]     trial;
  logic [bgu_pkg::DEN_W:0]     diff;
  logic                        ge;
  logic [bgu_pkg::DEN_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, lo_r[bgu_pkg::VAL_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[bgu_pkg::DEN_W-1:0] : trial[bgu_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bgu_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.dvs;
      lo_r  <= req.lo;
      rem_r <= req.hi;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[bgu_pkg::VAL_W-2:0], 1'b0};
      quo_r <= {quo_r[bgu_pkg::VAL_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: design/bgu_mac.sv
// shared signed multiplier with registered product and accumulator
// depends on bgu_pkg
module bgu_mac (
  input  logic                                clk,
  input  bgu_pkg::mac_ctl_t                   ctl,
  input  logic signed [bgu_pkg::VAL_W-1:0]    op_a,
  input  logic        [bgu_pkg::W_W-1:0]      op_b,
  output logic signed [bgu_pkg::PROD_W-1:0]   prod,
  output logic signed [bgu_pkg::ACC_W-1:0]    acc
);

  logic signed [bgu_pkg::PROD_W-1:0] prod_r;
  logic signed [bgu_pkg::ACC_W-1:0]  acc_r;
  logic signed [bgu_pkg::W_W:0]      b_s;

  assign b_s = $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    prod_r <= op_a * b_s;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= acc_r + {{(bgu_pkg::ACC_W-bgu_pkg::PROD_W){prod_r[bgu_pkg::PROD_W-1]}}, prod_r};
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

FILE: dv/tb_bilinear_grid_upsampler.sv
`timescale 1ns / 100ps
// self-checking testbench for bilinear_grid_upsampler: a directed plan, then random phases
// predicts untyped queries from its own copy of the coarse stores and registers; needs bgu_pkg
module tb_bilinear_grid_upsampler;

  localparam int SIDE        = 64;
  localparam int NODES       = SIDE * SIDE;
  localparam int TOP_RATIO   = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 200;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 65;
  localparam logic [bgu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0] V_MAX = 32'h7fffffff;
  localparam logic [31:0] V_MIN = 32'h80000000;

  typedef struct packed {
    logic        op;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [11:0] fx;
    logic [11:0] fy;
    logic [31:0] rho;
    logic [31:0] ux;
    logic [31:0] uy;
  } beat_t;

  typedef struct packed {
    logic [31:0] rho;
    logic [31:0] ux;
    logic [31:0] uy;
  } node_vals_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    beat_t                           beat;
    logic [bgu_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [bgu_pkg::CFG_DATA_W-1:0]  reg_val;
    bit                              typed;
    node_vals_t                      want;
  } plan_row_t;

  localparam node_vals_t N_FAR    = '{V_MAX, V_MIN, 32'hffffffff};
  localparam node_vals_t N_ORIGIN = '{V_MIN, V_MAX, 32'h00000001};
  localparam node_vals_t N_10     = '{32'hffffffff, 32'h00000003, V_MIN};
  localparam node_vals_t N_01     = '{32'h00000002, 32'hfffffffe, V_MAX};
  localparam node_vals_t N_11     = '{32'h00000005, 32'h80000001, 32'h01000000};

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic                            in_tuser;
  logic [bgu_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bgu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bgu_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [bgu_pkg::CFG_DATA_W-1:0]  cfg_data;

  bilinear_grid_upsampler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the coarse stores and registers
  logic [31:0] rho_mem [NODES];
  logic [31:0] ux_mem  [NODES];
  logic [31:0] uy_mem  [NODES];
  bit          written [NODES];
  logic [6:0]  ratio_r;
  logic [5:0]  org_x, org_y, last_x, last_y;

  node_vals_t  pending_q [$];
  plan_row_t   plan [$];
  bit          in_burst, out_burst;
  int          mismatches, results_checked, writes_sent, queries_sent, settings_seen;
  int          quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_row(input plan_row_t row);
    plan = {plan, row};
  endfunction

  function automatic int eff_ratio();
    int r;
    r = ratio_r;
    if (r == 0) r = 1;
    if (r > TOP_RATIO) r = TOP_RATIO;
    return r;
  endfunction

  function automatic int clip(input int c, input int last);
    return (c > last) ? last : c;
  endfunction

  function automatic void corner_nodes(input logic [11:0] fx, input logic [11:0] fy,
                                       output int nd[4]);
    int r, x0, y0, x1, y1;
    r  = eff_ratio();
    x0 = int'(org_x) + int'(fx) / r;
    y0 = int'(org_y) + int'(fy) / r;
    x1 = clip(x0 + 1, int'(last_x));
    y1 = clip(y0 + 1, int'(last_y));
    x0 = clip(x0, int'(last_x));
    y0 = clip(y0, int'(last_y));
    nd[0] = y0 * SIDE + x0;
    nd[1] = y0 * SIDE + x1;
    nd[2] = y1 * SIDE + x0;
    nd[3] = y1 * SIDE + x1;
  endfunction

  // weighted sum over r*r, rounded half up
  function automatic logic [31:0] blend(input logic [31:0] v[4], input longint w[4],
                                        input longint den);
    longint acc, num, q;
    int k;
    acc = 0;
    for (k = 0; k < 4; k++) acc += longint'($signed(v[k])) * w[k];
    num = acc + den / 2;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q[31:0];
  endfunction

  function automatic node_vals_t interpolate(input logic [11:0] fx, input logic [11:0] fy);
    int nd[4];
    int r, a, b, k;
    longint w[4];
    logic [31:0] vr[4], vx[4], vy[4];
    node_vals_t res;
    r = eff_ratio();
    a = int'(fx) % r;
    b = int'(fy) % r;
    corner_nodes(fx, fy, nd);
    w[0] = (r - a) * (r - b);
    w[1] = a * (r - b);
    w[2] = (r - a) * b;
    w[3] = a * b;
    for (k = 0; k < 4; k++) begin
      vr[k] = rho_mem[nd[k]];
      vx[k] = ux_mem[nd[k]];
      vy[k] = uy_mem[nd[k]];
    end
    res.rho = blend(vr, w, r * r);
    res.ux  = blend(vx, w, r * r);
    res.uy  = blend(vy, w, r * r);
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = V_MAX;
      1: v = V_MIN;
      2: v = 32'h0;
      3: v = 32'hffffffff;
      4: v = 32'($urandom_range(0, 15)) - 32'd8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic beat_t random_beat(input logic op);
    beat_t b;
    b.op  = op;
    b.cx  = 6'($urandom_range(0, 63));
    b.cy  = 6'($urandom_range(0, 63));
    b.fx  = 12'($urandom_range(0, 4095));
    b.fy  = 12'($urandom_range(0, 4095));
    b.rho = pick_value();
    b.ux  = pick_value();
    b.uy  = pick_value();
    return b;
  endfunction

  function automatic plan_row_t row_write(input logic [5:0] cx, input logic [5:0] cy,
                                          input node_vals_t nv);
    plan_row_t row;
    row.kind    = ROW_BEAT;
    row.beat    = '0;
    row.beat.op = bgu_pkg::OP_WRITE;
    row.beat.cx = cx;
    row.beat.cy = cy;
    row.beat.rho = nv.rho;
    row.beat.ux = nv.ux;
    row.beat.uy = nv.uy;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic plan_row_t row_query(input logic [11:0] fx, input logic [11:0] fy,
                                          input bit typed, input node_vals_t nv);
    plan_row_t row;
    row.kind    = ROW_BEAT;
    row.beat    = '0;
    row.beat.op = bgu_pkg::OP_QUERY;
    row.beat.fx = fx;
    row.beat.fy = fy;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed   = typed;
    row.want    = nv;
    return row;
  endfunction

  function automatic plan_row_t row_reg(input logic [bgu_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [bgu_pkg::CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.kind    = ROW_REG;
    row.beat    = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // one input beat; the shadow is updated when the beat is taken
  task automatic send_beat(input beat_t b, input bit typed, input node_vals_t want);
    int gap, n;
    node_vals_t res;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= b.op;
    in_tdata  <= {4'b0, b.uy, b.ux, b.rho, b.fy, b.fx, b.cy, b.cx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (b.op == bgu_pkg::OP_WRITE) begin
      n = int'(b.cy) * SIDE + int'(b.cx);
      rho_mem[n] = b.rho;
      ux_mem[n]  = b.ux;
      uy_mem[n]  = b.uy;
      written[n] = 1'b1;
      writes_sent++;
    end else begin
      res = typed ? want : interpolate(b.fx, b.fy);
      pending_q = {pending_q, res};
      queries_sent++;
    end
  endtask

  task automatic reg_write(input logic [bgu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bgu_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bgu_pkg::CFG_RATIO:  ratio_r = val;
      bgu_pkg::CFG_ORG_X:  org_x   = val[5:0];
      bgu_pkg::CFG_ORG_Y:  org_y   = val[5:0];
      bgu_pkg::CFG_LAST_X: last_x  = val[5:0];
      bgu_pkg::CFG_LAST_Y: last_y  = val[5:0];
      default: ;
    endcase
  endtask

  // sender holds off until every query has answered and the sequencer has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    node_vals_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rho = out_tdata[31:0];
      got.ux  = out_tdata[63:32];
      got.uy  = out_tdata[95:64];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with no query outstanding: %h", got);
      end else begin
        want = pending_q.pop_front();
        results_checked++;
        if (got.rho !== want.rho) note_mismatch("rho_out", want.rho, got.rho);
        if (got.ux !== want.ux) note_mismatch("ux_out", want.ux, got.ux);
        if (got.uy !== want.uy) note_mismatch("uy_out", want.uy, got.uy);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int p, sent, k;
    int nd[4];
    int r;
    beat_t b;
    node_vals_t none;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 0;
    ratio_r    = bgu_pkg::RATIO_RST;
    org_x      = bgu_pkg::ORG_RST;
    org_y      = bgu_pkg::ORG_RST;
    last_x     = bgu_pkg::LAST_RST;
    last_y     = bgu_pkg::LAST_RST;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    none       = '0;
    mismatches = 0;
    results_checked = 0;
    writes_sent = 0;
    queries_sent = 0;
    settings_seen = 1;

    // reset values, clamping at the far corner and at a zero last index
    add_row(row_write(6'd63, 6'd63, N_FAR));
    add_row(row_query(12'd63, 12'd63, 1'b1, N_FAR));
    add_row(row_query(12'd4095, 12'd4095, 1'b1, N_FAR));
    add_row(row_write(6'd0, 6'd0, N_ORIGIN));
    add_row(row_write(6'd1, 6'd0, N_10));
    add_row(row_write(6'd0, 6'd1, N_01));
    add_row(row_write(6'd1, 6'd1, N_11));
    add_row(row_query(12'd0, 12'd0, 1'b1, N_ORIGIN));
    add_row(row_reg(bgu_pkg::CFG_LAST_X, 7'd0));
    add_row(row_reg(bgu_pkg::CFG_LAST_Y, 7'd0));
    add_row(row_query(12'd4095, 12'd4095, 1'b1, N_ORIGIN));
    add_row(row_reg(bgu_pkg::CFG_LAST_X, 7'd63));
    add_row(row_reg(bgu_pkg::CFG_LAST_Y, 7'd63));
    // fractional weights and rounding
    add_row(row_reg(bgu_pkg::CFG_RATIO, 7'd2));
    add_row(row_query(12'd1, 12'd1, 1'b0, none));
    add_row(row_query(12'd1, 12'd0, 1'b0, none));
    add_row(row_query(12'd0, 12'd1, 1'b0, none));
    // ratio zero acts as one
    add_row(row_reg(bgu_pkg::CFG_RATIO, 7'd0));
    add_row(row_query(12'd0, 12'd0, 1'b1, N_ORIGIN));
    // ratio above the maximum saturates
    add_row(row_reg(bgu_pkg::CFG_RATIO, 7'd127));
    add_row(row_query(12'd63, 12'd63, 1'b0, none));
    add_row(row_query(12'd4095, 12'd4095, 1'b1, N_FAR));
    add_row(row_reg(bgu_pkg::CFG_RATIO, 7'd3));
    add_row(row_query(12'd2, 12'd1, 1'b0, none));
    // origin at the grid edge
    add_row(row_reg(bgu_pkg::CFG_RATIO, 7'd1));
    add_row(row_reg(bgu_pkg::CFG_ORG_X, 7'h7f));
    add_row(row_reg(bgu_pkg::CFG_ORG_Y, 7'h3f));
    add_row(row_query(12'd0, 12'd0, 1'b1, N_FAR));
    add_row(row_query(12'd4095, 12'd0, 1'b1, N_FAR));
    // unknown register index leaves everything alone
    add_row(row_reg(CFG_UNUSED, 7'h7f));
    add_row(row_query(12'd0, 12'd4095, 1'b1, N_FAR));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        reg_write(plan[i].reg_idx, plan[i].reg_val);
        settings_seen++;
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      in_burst  = (p % 3 == 2);
      out_burst = (p % 2 == 1);
      wait_idle();
      case (p)
        0: begin
          reg_write(bgu_pkg::CFG_RATIO, 7'd64);
          reg_write(bgu_pkg::CFG_ORG_X, 7'd0);
          reg_write(bgu_pkg::CFG_ORG_Y, 7'd0);
          reg_write(bgu_pkg::CFG_LAST_X, 7'd63);
          reg_write(bgu_pkg::CFG_LAST_Y, 7'd63);
        end
        1: begin
          reg_write(bgu_pkg::CFG_RATIO, 7'd1);
          reg_write(bgu_pkg::CFG_ORG_X, 7'($urandom_range(0, 127)));
          reg_write(bgu_pkg::CFG_ORG_Y, 7'($urandom_range(0, 127)));
          reg_write(bgu_pkg::CFG_LAST_X, 7'd63);
          reg_write(bgu_pkg::CFG_LAST_Y, 7'd63);
        end
        default: begin
          case ($urandom_range(0, 7))
            0: reg_write(bgu_pkg::CFG_RATIO, 7'd0);
            1: reg_write(bgu_pkg::CFG_RATIO, 7'($urandom_range(65, 127)));
            2: reg_write(bgu_pkg::CFG_RATIO, 7'd64);
            default: reg_write(bgu_pkg::CFG_RATIO, 7'($urandom_range(1, 16)));
          endcase
          reg_write(bgu_pkg::CFG_ORG_X, 7'($urandom_range(0, 127)));
          reg_write(bgu_pkg::CFG_ORG_Y, 7'($urandom_range(0, 127)));
          reg_write(bgu_pkg::CFG_LAST_X, 7'($urandom_range(0, 127)));
          reg_write(bgu_pkg::CFG_LAST_Y, 7'($urandom_range(0, 127)));
        end
      endcase
      settings_seen++;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 45) begin
          send_beat(random_beat(bgu_pkg::OP_WRITE), 1'b0, none);
          sent++;
        end else begin
          b = random_beat(bgu_pkg::OP_QUERY);
          r = eff_ratio();
          if ($urandom_range(0, 9) < 7) b.fx = 12'($urandom_range(0, r * 6));
          if ($urandom_range(0, 9) < 7) b.fy = 12'($urandom_range(0, r * 6));
          // fill any corner not yet written before the query reads it
          corner_nodes(b.fx, b.fy, nd);
          for (k = 0; k < 4; k++) begin
            if (!written[nd[k]]) begin
              send_beat('{bgu_pkg::OP_WRITE, 6'(nd[k] % SIDE), 6'(nd[k] / SIDE),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          pick_value(), pick_value(), pick_value()}, 1'b0, none);
              sent++;
            end
          end
          send_beat(b, 1'b0, none);
          sent++;
        end
      end
    end

    wait_idle();
    $display("covered %0d coarse writes and %0d fine queries under %0d register settings",
             writes_sent, queries_sent, settings_seen);
    $display("%0d result beats compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bgu_pkg.sv
design/bgu_ram.sv
design/bgu_divider.sv
design/bgu_mac.sv
design/bilinear_grid_upsampler.sv
dv/tb_bilinear_grid_upsampler.sv
